/* sv/prq_pkg.sv */
package prq_pkg;

  localparam int NUM_CLASSES = 4;

  localparam logic [1:0] CLS_NORMAL = 2'd1;
  localparam logic [1:0] CLS_LOW    = 2'd2;

  localparam logic [5:0]  RST_CAPACITY  = 6'd32;
  localparam logic [6:0]  RST_HIGH_PCT  = 7'd80;
  localparam logic [6:0]  RST_LOW_PCT   = 7'd50;
  localparam logic        RST_PRIO_EN   = 1'b1;
  localparam logic [31:0] RST_TIMEOUT   = 32'd30000;
  localparam logic [31:0] RST_EVICT_INT = 32'd1000;
  localparam logic [31:0] RST_AGING_INT = 32'd5000;

  localparam logic [6:0]  PCT_50  = 7'd50;
  localparam logic [6:0]  PCT_75  = 7'd75;
  localparam logic [6:0]  PCT_90  = 7'd90;
  localparam logic [6:0]  PCT_100 = 7'd100;

  localparam logic [10:0] RETRY_BASE_50  = 11'd50;
  localparam logic [10:0] RETRY_BASE_75  = 11'd150;
  localparam logic [10:0] RETRY_BASE_90  = 11'd400;
  localparam logic [10:0] RETRY_BASE_100 = 11'd1000;
  localparam logic [10:0] RETRY_ADD_MAX  = 11'd500;
  localparam logic [10:0] RETRY_MAX      = 11'd2000;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } prq_cmd_code_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_DEQUEUED  = 3'd2,
    KIND_EMPTY     = 3'd3,
    KIND_EVICTED   = 3'd4,
    KIND_BP_CHANGE = 3'd5,
    KIND_TICK_DONE = 3'd6
  } prq_kind_t;

  typedef enum logic [2:0] {
    REG_CAPACITY  = 3'd0,
    REG_HIGH_PCT  = 3'd1,
    REG_LOW_PCT   = 3'd2,
    REG_PRIO_EN   = 3'd3,
    REG_TIMEOUT   = 3'd4,
    REG_EVICT_INT = 3'd5,
    REG_AGING_INT = 3'd6
  } prq_reg_t;

  typedef enum logic [2:0] {
    EM_PRIMARY,
    EM_REJECT,
    EM_EMPTY,
    EM_EVICT,
    EM_BP,
    EM_TICK
  } prq_emit_t;

  typedef enum logic [2:0] {
    SCAN_FREE,
    SCAN_DEQ,
    SCAN_PICK,
    SCAN_EV_MARK,
    SCAN_AG_MARK
  } prq_scan_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ENQ,
    S_ENQ_SCAN,
    S_ENQ_WR,
    S_REJ_EMIT,
    S_DEQ_SCAN,
    S_DEQ_DEC,
    S_DEQ_REM,
    S_EMPTY_EMIT,
    S_PRI_EMIT,
    S_BP_UPD,
    S_DIV_WAIT,
    S_BP_EMIT,
    S_TICK,
    S_EV_MARK,
    S_EV_COMMIT,
    S_EV_PICK,
    S_EV_DEC,
    S_EV_EMIT,
    S_AG_CHECK,
    S_AG_MARK,
    S_AG_PICK,
    S_AG_DEC,
    S_AG_MOVE,
    S_TICK_EMIT
  } prq_state_t;

  typedef struct packed {
    logic [5:0]  capacity;
    logic [6:0]  high_pct;
    logic [6:0]  low_pct;
    logic        prio_en;
    logic [31:0] timeout;
    logic [31:0] evict_int;
    logic [31:0] aging_int;
  } prq_cfg_t;

  typedef struct packed {
    logic      in_load;
    logic      clr_found;
    logic      scan;
    prq_scan_t scan_mode;
    logic      enq_write;
    logic      deq_remove;
    logic      tick;
    logic      ev_commit;
    logic      ev_clear;
    logic      ag_move;
    logic      bp_toggle;
    logic      div_start;
    logic      emit;
    prq_emit_t emit_sel;
    logic      last;
  } prq_ctl_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic full;
    logic bp_chg;
    logic ev_fire;
    logic ag_fire;
    logic prio_en;
    logic need_div;
    logic div_done;
    logic out_free;
    logic ev_any;
  } prq_sts_t;

  function automatic logic util_ge(input logic [15:0] tot100, input logic [6:0] p,
                                   input logic [5:0] cap);
    logic res;
    if (cap == 6'd0) res = (p == 7'd0);
    else res = (tot100 >= 16'(p) * 16'(cap));
    return res;
  endfunction

  function automatic logic util_le(input logic [15:0] tot100, input logic [6:0] p,
                                   input logic [5:0] cap);
    logic res;
    if (cap == 6'd0) res = 1'b1;
    else res = (tot100 <= 16'(p) * 16'(cap));
    return res;
  endfunction

endpackage

/* sv/prq_cfg.sv */
module prq_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output prq_pkg::prq_cfg_t  cfg
);
  import prq_pkg::*;

  prq_cfg_t cfg_r;
  prq_reg_t sel;
  logic     wr;

  assign sel        = prq_reg_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity  <= RST_CAPACITY;
      cfg_r.high_pct  <= RST_HIGH_PCT;
      cfg_r.low_pct   <= RST_LOW_PCT;
      cfg_r.prio_en   <= RST_PRIO_EN;
      cfg_r.timeout   <= RST_TIMEOUT;
      cfg_r.evict_int <= RST_EVICT_INT;
      cfg_r.aging_int <= RST_AGING_INT;
    end else if (wr) begin
      case (sel)
        REG_CAPACITY:  cfg_r.capacity  <= cfg_pwdata[5:0];
        REG_HIGH_PCT:  cfg_r.high_pct  <= cfg_pwdata[6:0];
        REG_LOW_PCT:   cfg_r.low_pct   <= cfg_pwdata[6:0];
        REG_PRIO_EN:   cfg_r.prio_en   <= cfg_pwdata[0];
        REG_TIMEOUT:   cfg_r.timeout   <= cfg_pwdata;
        REG_EVICT_INT: cfg_r.evict_int <= cfg_pwdata;
        REG_AGING_INT: cfg_r.aging_int <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_CAPACITY:  cfg_prdata = {26'd0, cfg_r.capacity};
      REG_HIGH_PCT:  cfg_prdata = {25'd0, cfg_r.high_pct};
      REG_LOW_PCT:   cfg_prdata = {25'd0, cfg_r.low_pct};
      REG_PRIO_EN:   cfg_prdata = {31'd0, cfg_r.prio_en};
      REG_TIMEOUT:   cfg_prdata = cfg_r.timeout;
      REG_EVICT_INT: cfg_prdata = cfg_r.evict_int;
      REG_AGING_INT: cfg_prdata = cfg_r.aging_int;
      default:       cfg_prdata = 32'd0;
    endcase
  end

endmodule

/* sv/prq_div.sv */
module prq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [35:0] divisor,
  output logic        done,
  output logic [47:0] quot
);

  logic [36:0] rem_r;
  logic [47:0] quo_r;
  logic [35:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [36:0] shifted;
  logic        take;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_r[35:0], quo_r[47]};
  assign take    = shifted >= {1'b0, dvs_r};
  assign done    = done_r;
  assign quot    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 37'd0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_r <= {quo_r[46:0], take};
    end
  end

endmodule

/* sv/prq_dp.sv */
module prq_dp #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prq_pkg::prq_cfg_t  cfg,
  input  prq_pkg::prq_ctl_t  ctl,
  output prq_pkg::prq_sts_t  sts,
  input  logic [23:0]        in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [71:0]        out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);
  import prq_pkg::*;

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW   = $clog2(DEPTH + 1);

  // slot store
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] mark_r;
  logic [15:0]      tag_r   [DEPTH];
  logic [1:0]       cls_r   [DEPTH];
  logic [31:0]      stamp_r [DEPTH];
  logic [31:0]      ord_r   [DEPTH];

  logic [IDXW-1:0] idx_r, best_r;
  logic            found_r;
  logic [1:0]      best_cls_r;
  logic [31:0]     best_ord_r;
  logic [TW-1:0]   total_r, ne_r;
  logic [31:0]     seq_r, now_r, ev_cd_r, ag_cd_r, served_r;
  logic [47:0]     wait_sum_r;
  logic            bp_r;
  logic [15:0]     id_r;
  logic [2:0]      pri_r;

  prq_kind_t   p_kind_r;
  logic [15:0] p_tag_r;
  logic [1:0]  p_cls_r;
  logic [31:0] p_wait_r;

  logic        out_valid_r, out_last_r, out_bp_r;
  prq_kind_t   out_kind_r;
  logic [15:0] out_tag_r;
  logic [1:0]  out_cls_r;
  logic [31:0] out_wait_r;
  logic [10:0] out_retry_r;
  logic [5:0]  out_occ_r;

  logic        scan_end, cur_valid, better, take;
  logic [1:0]  cur_cls, req_cls;
  logic [31:0] cur_ord, cur_age, best_age;
  logic [15:0] tot100;
  logic        ev_fire, ag_fire, ge50;
  logic [47:0] quot;
  logic        div_done;
  logic [35:0] divisor;
  logic [10:0] base, add, retry_sum, retry;
  prq_kind_t   e_kind;
  logic [15:0] e_tag;
  logic [1:0]  e_cls;
  logic [31:0] e_wait;
  logic [10:0] e_retry;
  logic        out_free;

  assign scan_end  = idx_r == IDXW'(DEPTH - 1);
  assign cur_valid = valid_r[idx_r];
  assign cur_cls   = cls_r[idx_r];
  assign cur_ord   = ord_r[idx_r];
  assign cur_age   = now_r - stamp_r[idx_r];
  assign best_age  = now_r - stamp_r[best_r];
  assign better    = !found_r || (cur_cls < best_cls_r) ||
                     ((cur_cls == best_cls_r) && (cur_ord < best_ord_r));
  assign req_cls   = (cfg.prio_en && (pri_r < 3'(NUM_CLASSES))) ? pri_r[1:0] : CLS_NORMAL;
  assign tot100    = 16'(total_r) * 16'd100;
  assign ev_fire   = ev_cd_r <= 32'd1;
  assign ag_fire   = ag_cd_r <= 32'd1;
  assign ge50      = util_ge(tot100, PCT_50, cfg.capacity);
  assign divisor   = 36'({served_r, 3'b000}) + 36'({served_r, 1'b0});
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (ctl.scan_mode)
      SCAN_FREE: take = !cur_valid && !found_r;
      SCAN_DEQ:  take = cur_valid && better;
      SCAN_PICK: take = mark_r[idx_r] && better;
      default:   take = 1'b0;
    endcase
  end

  assign sts.scan_end = scan_end;
  assign sts.found    = found_r;
  assign sts.full     = (total_r >= TW'(cfg.capacity)) || (total_r >= TW'(DEPTH));
  assign sts.bp_chg   = (!bp_r && util_ge(tot100, cfg.high_pct, cfg.capacity)) ||
                        (bp_r && util_le(tot100, cfg.low_pct, cfg.capacity));
  assign sts.ev_fire  = ev_fire;
  assign sts.ag_fire  = ag_fire;
  assign sts.prio_en  = cfg.prio_en;
  assign sts.need_div = ge50 && (served_r != 32'd0);
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;
  assign sts.ev_any   = ne_r != '0;

  prq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (wait_sum_r),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // retry delay from utilization bands plus mean wait / 10
  always_comb begin
    if (util_ge(tot100, PCT_100, cfg.capacity))     base = RETRY_BASE_100;
    else if (util_ge(tot100, PCT_90, cfg.capacity)) base = RETRY_BASE_90;
    else if (util_ge(tot100, PCT_75, cfg.capacity)) base = RETRY_BASE_75;
    else                                            base = RETRY_BASE_50;
    if (served_r == 32'd0)               add = 11'd0;
    else if (quot >= 48'(RETRY_ADD_MAX)) add = RETRY_ADD_MAX;
    else                                 add = quot[10:0];
    retry_sum = base + add;
    if (!ge50)                       retry = 11'd0;
    else if (retry_sum > RETRY_MAX) retry = RETRY_MAX;
    else                             retry = retry_sum;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      mark_r     <= '0;
      idx_r      <= '0;
      found_r    <= 1'b0;
      total_r    <= '0;
      ne_r       <= '0;
      seq_r      <= 32'd0;
      now_r      <= 32'd0;
      ev_cd_r    <= RST_EVICT_INT;
      ag_cd_r    <= RST_AGING_INT;
      served_r   <= 32'd0;
      wait_sum_r <= 48'd0;
      bp_r       <= 1'b0;
    end else begin
      if (ctl.in_load) ne_r <= '0;
      if (ctl.clr_found) found_r <= 1'b0;
      if (ctl.scan) begin
        idx_r <= scan_end ? '0 : idx_r + IDXW'(1);
        if (take) found_r <= 1'b1;
        if (ctl.scan_mode == SCAN_EV_MARK) begin
          mark_r[idx_r] <= cur_valid && (cur_age > cfg.timeout);
          if (cur_valid && (cur_age > cfg.timeout)) ne_r <= ne_r + TW'(1);
        end else if (ctl.scan_mode == SCAN_AG_MARK) begin
          mark_r[idx_r] <= cur_valid && (cur_cls >= CLS_LOW) && (cur_age > cfg.aging_int);
        end
      end
      if (ctl.enq_write) begin
        valid_r[best_r] <= 1'b1;
        total_r         <= total_r + TW'(1);
        seq_r           <= seq_r + 32'd1;
      end
      if (ctl.deq_remove) begin
        valid_r[best_r] <= 1'b0;
        total_r         <= total_r - TW'(1);
        served_r        <= served_r + 32'd1;
        wait_sum_r      <= wait_sum_r + 48'(best_age);
      end
      if (ctl.ev_commit) begin
        valid_r <= valid_r & ~mark_r;
        total_r <= total_r - ne_r;
      end
      if (ctl.ev_clear) mark_r[best_r] <= 1'b0;
      if (ctl.ag_move) begin
        mark_r[best_r] <= 1'b0;
        seq_r          <= seq_r + 32'd1;
      end
      if (ctl.bp_toggle) bp_r <= !bp_r;
      if (ctl.tick) begin
        now_r   <= now_r + 32'd1;
        ev_cd_r <= ev_fire ? ((cfg.evict_int == 32'd0) ? 32'd1 : cfg.evict_int)
                           : ev_cd_r - 32'd1;
        ag_cd_r <= ag_fire ? ((cfg.aging_int == 32'd0) ? 32'd1 : cfg.aging_int)
                           : ag_cd_r - 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      id_r  <= in_tdata[15:0];
      pri_r <= in_tdata[18:16];
    end
    if (ctl.scan && take) begin
      best_r     <= idx_r;
      best_cls_r <= cur_cls;
      best_ord_r <= cur_ord;
    end
    if (ctl.enq_write) begin
      tag_r[best_r]   <= id_r;
      cls_r[best_r]   <= req_cls;
      stamp_r[best_r] <= now_r;
      ord_r[best_r]   <= seq_r;
      p_kind_r        <= KIND_ACCEPTED;
      p_tag_r         <= id_r;
      p_cls_r         <= req_cls;
      p_wait_r        <= 32'd0;
    end
    if (ctl.deq_remove) begin
      p_kind_r <= KIND_DEQUEUED;
      p_tag_r  <= tag_r[best_r];
      p_cls_r  <= cls_r[best_r];
      p_wait_r <= best_age;
    end
    if (ctl.ag_move) begin
      ord_r[best_r] <= seq_r;
      cls_r[best_r] <= CLS_NORMAL;
    end
  end

  always_comb begin
    e_kind  = KIND_TICK_DONE;
    e_tag   = 16'd0;
    e_cls   = 2'd0;
    e_wait  = 32'd0;
    e_retry = 11'd0;
    case (ctl.emit_sel)
      EM_PRIMARY: begin
        e_kind = p_kind_r;
        e_tag  = p_tag_r;
        e_cls  = p_cls_r;
        e_wait = p_wait_r;
      end
      EM_REJECT: begin
        e_kind = KIND_REJECTED;
        e_tag  = id_r;
        e_cls  = req_cls;
      end
      EM_EMPTY: e_kind = KIND_EMPTY;
      EM_EVICT: begin
        e_kind = KIND_EVICTED;
        e_tag  = tag_r[best_r];
        e_cls  = cls_r[best_r];
        e_wait = best_age;
      end
      EM_BP: begin
        e_kind  = KIND_BP_CHANGE;
        e_retry = retry;
      end
      EM_TICK: e_kind = KIND_TICK_DONE;
      default: e_kind = KIND_TICK_DONE;
    endcase
  end

  // output register, held until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_kind_r  <= e_kind;
      out_tag_r   <= e_tag;
      out_cls_r   <= e_cls;
      out_wait_r  <= e_wait;
      out_bp_r    <= bp_r;
      out_retry_r <= e_retry;
      out_occ_r   <= 6'(total_r);
      out_last_r  <= ctl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_occ_r, out_retry_r, out_bp_r, out_wait_r, out_cls_r,
                       out_tag_r};

endmodule

/* sv/prq_ctrl.sv */
module prq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic [1:0]         in_tuser,
  output logic               in_tready,
  input  prq_pkg::prq_sts_t  sts,
  output prq_pkg::prq_ctl_t  ctl
);
  import prq_pkg::*;

  prq_state_t    state_r, state_nxt;
  logic          ag_fire_r, in_tick_r;
  prq_cmd_code_t cmd;
  logic          fire;

  assign cmd       = prq_cmd_code_t'(in_tuser);
  assign in_tready = state_r == S_IDLE;
  assign fire      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ag_fire_r <= 1'b0;
      in_tick_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) in_tick_r <= 1'b0;
      if (state_r == S_TICK) begin
        in_tick_r <= 1'b1;
        ag_fire_r <= sts.ag_fire;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          case (cmd)
            CMD_ENQ:  state_nxt = S_ENQ;
            CMD_DEQ:  state_nxt = S_DEQ_SCAN;
            CMD_TICK: state_nxt = S_TICK;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENQ:        state_nxt = sts.full ? S_REJ_EMIT : S_ENQ_SCAN;
      S_ENQ_SCAN:   if (sts.scan_end) state_nxt = S_ENQ_WR;
      S_ENQ_WR:     state_nxt = S_PRI_EMIT;
      S_REJ_EMIT:   if (sts.out_free) state_nxt = S_IDLE;
      S_DEQ_SCAN:   if (sts.scan_end) state_nxt = S_DEQ_DEC;
      S_DEQ_DEC:    state_nxt = sts.found ? S_DEQ_REM : S_EMPTY_EMIT;
      S_DEQ_REM:    state_nxt = S_PRI_EMIT;
      S_EMPTY_EMIT: if (sts.out_free) state_nxt = S_IDLE;
      S_PRI_EMIT:   if (sts.out_free) state_nxt = sts.bp_chg ? S_BP_UPD : S_IDLE;
      S_BP_UPD:     state_nxt = sts.need_div ? S_DIV_WAIT : S_BP_EMIT;
      S_DIV_WAIT:   if (sts.div_done) state_nxt = S_BP_EMIT;
      S_BP_EMIT:    if (sts.out_free) state_nxt = in_tick_r ? S_AG_CHECK : S_IDLE;
      S_TICK:       state_nxt = sts.ev_fire ? S_EV_MARK : S_AG_CHECK;
      S_EV_MARK:    if (sts.scan_end) state_nxt = S_EV_COMMIT;
      S_EV_COMMIT:  state_nxt = S_EV_PICK;
      S_EV_PICK:    if (sts.scan_end) state_nxt = S_EV_DEC;
      S_EV_DEC: begin
        if (sts.found) state_nxt = S_EV_EMIT;
        else if (sts.ev_any && sts.bp_chg) state_nxt = S_BP_UPD;
        else state_nxt = S_AG_CHECK;
      end
      S_EV_EMIT:    if (sts.out_free) state_nxt = S_EV_PICK;
      S_AG_CHECK:   state_nxt = (ag_fire_r && sts.prio_en) ? S_AG_MARK : S_TICK_EMIT;
      S_AG_MARK:    if (sts.scan_end) state_nxt = S_AG_PICK;
      S_AG_PICK:    if (sts.scan_end) state_nxt = S_AG_DEC;
      S_AG_DEC:     state_nxt = sts.found ? S_AG_MOVE : S_TICK_EMIT;
      S_AG_MOVE:    state_nxt = S_AG_PICK;
      S_TICK_EMIT:  if (sts.out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.scan_mode = SCAN_FREE;
    ctl.emit_sel  = EM_TICK;
    case (state_r)
      S_IDLE: begin
        ctl.in_load   = fire;
        ctl.clr_found = fire;
      end
      S_ENQ_SCAN: begin
        ctl.scan      = 1'b1;
        ctl.scan_mode = SCAN_FREE;
      end
      S_ENQ_WR: ctl.enq_write = 1'b1;
      S_REJ_EMIT: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = EM_REJECT;
        ctl.last     = 1'b1;
      end
      S_DEQ_SCAN: begin
        ctl.scan      = 1'b1;
        ctl.scan_mode = SCAN_DEQ;
      end
      S_DEQ_REM: ctl.deq_remove = 1'b1;
      S_EMPTY_EMIT: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = EM_EMPTY;
        ctl.last     = 1'b1;
      end
      S_PRI_EMIT: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = EM_PRIMARY;
        ctl.last     = !sts.bp_chg;
      end
      S_BP_UPD: begin
        ctl.bp_toggle = 1'b1;
        ctl.div_start = sts.need_div;
      end
      S_BP_EMIT: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = EM_BP;
        ctl.last     = !in_tick_r;
      end
      S_TICK: ctl.tick = 1'b1;
      S_EV_MARK: begin
        ctl.scan      = 1'b1;
        ctl.scan_mode = SCAN_EV_MARK;
      end
      S_EV_COMMIT: begin
        ctl.ev_commit = 1'b1;
        ctl.clr_found = 1'b1;
      end
      S_EV_PICK: begin
        ctl.scan      = 1'b1;
        ctl.scan_mode = SCAN_PICK;
      end
      S_EV_EMIT: begin
        ctl.emit      = sts.out_free;
        ctl.emit_sel  = EM_EVICT;
        ctl.ev_clear  = sts.out_free;
        ctl.clr_found = sts.out_free;
      end
      S_AG_MARK: begin
        ctl.scan      = 1'b1;
        ctl.scan_mode = SCAN_AG_MARK;
        ctl.clr_found = 1'b1;
      end
      S_AG_PICK: begin
        ctl.scan      = 1'b1;
        ctl.scan_mode = SCAN_PICK;
      end
      S_AG_MOVE: begin
        ctl.ag_move   = 1'b1;
        ctl.clr_found = 1'b1;
      end
      S_TICK_EMIT: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = EM_TICK;
        ctl.last     = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* sv/priority_request_queue_backpressure.sv */
// Priority request queue with four FIFO classes, aging, timeout eviction and
// backpressure reporting.
// Input channel in_*: one command per transaction (enqueue, dequeue, tick).
// Output channel out_*: one or more results per command; tlast marks the
// final result of a command. Configuration goes through the cfg_* port; the
// user must write it only while the block is idle (not enforced by the block).
// Commands are handled one at a time. An enqueue that is not rejected and a
// dequeue each scan every slot, one slot a cycle. A backpressure change may
// also wait for the 48-step mean-wait divider. A tick runs, when eviction
// fires, a marking scan, a commit and picking scans until no marked entry is
// left, and when aging fires, a marking scan and such picking scans.
// Reset clears the queue, the tick counters and backpressure and loads the
// register defaults; no clearing pass is needed.
// When the receiver stalls, the pending result stays in the output register
// and the block waits before producing the next one.
module priority_request_queue_backpressure #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // req_id[15:0], priority_req[18:16]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // tag[15:0], class_out[17:16], wait_ticks[49:18], backpressure[50],
  // retry_after_ms[61:51], occupancy[67:62]
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import prq_pkg::*;

  prq_cfg_t cfg;
  prq_ctl_t ctl;
  prq_sts_t sts;

  prq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  prq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != CMD_NOP)) |=> !in_tready)
    else $error("block took a command while still busy");

  a_tick_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_TICK_DONE)) |-> out_tlast)
    else $error("tick done result not marked last");

  a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_EMPTY)) |-> (out_tdata[67:62] == 6'd0))
    else $error("empty result with entries queued");

  a_no_emit_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit) |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule
